FILE: rtl/stsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_pkg
// shared types and constants of the sorted tuple set insert block
// ----------------------------------------------------------------------------
package stsi_pkg;

    localparam int CAPACITY        = 1024;
    localparam int MAX_CLIQUE_SIZE = 8;
    localparam int VERTEX_BITS     = 16;

    localparam int PORT_BITS  = 16;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int K_BITS     = $clog2(MAX_CLIQUE_SIZE + 1);
    localparam int ROW_BITS   = VERTEX_BITS * MAX_CLIQUE_SIZE;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_PRESENT  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef logic [VERTEX_BITS-1:0] vertex_t;
    typedef vertex_t [MAX_CLIQUE_SIZE-1:0] tuple_t;

    // a classified item handed from front to back
    typedef struct packed {
        tuple_t            tuple;
        logic [K_BITS-1:0] k;
    } job_t;

    function automatic logic [K_BITS-1:0] active_size(input logic [3:0] cs);
        logic [K_BITS-1:0] r;
        if (cs == 4'd0) begin
            r = K_BITS'(1);
        end else if (32'(cs) > MAX_CLIQUE_SIZE) begin
            r = K_BITS'(MAX_CLIQUE_SIZE);
        end else begin
            r = K_BITS'(cs);
        end
        return r;
    endfunction

endpackage

FILE: rtl/sorted_tuple_set_insert_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_tuple_set_insert_top
// set of sorted vertex tuples kept in lexicographic order, insert by search
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  s_        s_valid/s_ready    s_vertex_0 .. s_vertex_7
//  m_        m_valid/m_ready    m_status, m_position, m_entry_count
//  config    cfg_we             cfg_data (clique_size)
//
//  front sort holds a beat through accept, 8 odd-even passes and hand-off
//  back runs a probe and a compare state per search step (about 11 probes),
//  then a read and a move state per row shifted up through the one ram
//  the ram sets the pace; front and back overlap through a 2-deep queue
//  reset clears the entry count and control state; ram contents need no clear
//  the result waits in the back unit until taken; the front keeps sorting
// ----------------------------------------------------------------------------
module sorted_tuple_set_insert_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_vertex_0,
    input  logic [15:0] s_vertex_1,
    input  logic [15:0] s_vertex_2,
    input  logic [15:0] s_vertex_3,
    input  logic [15:0] s_vertex_4,
    input  logic [15:0] s_vertex_5,
    input  logic [15:0] s_vertex_6,
    input  logic [15:0] s_vertex_7,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_position,
    output logic [10:0] m_entry_count,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data
);
    import stsi_pkg::*;

    logic [3:0]  clique_size_reg;
    tuple_t      in_tuple;
    logic        f_valid, f_ready, q_valid, q_ready;
    job_t        f_job, q_job;
    logic [15:0] raw [8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clique_size_reg <= 4'd4;
        end else if (cfg_we) begin
            clique_size_reg <= cfg_data;
        end
    end

    // gather ports and trim to vertex width
    assign raw[0] = s_vertex_0;
    assign raw[1] = s_vertex_1;
    assign raw[2] = s_vertex_2;
    assign raw[3] = s_vertex_3;
    assign raw[4] = s_vertex_4;
    assign raw[5] = s_vertex_5;
    assign raw[6] = s_vertex_6;
    assign raw[7] = s_vertex_7;

    always_comb begin
        for (int i = 0; i < MAX_CLIQUE_SIZE; i++) begin
            in_tuple[i] = VERTEX_BITS'(raw[i]);
        end
    end

    stsi_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_tuple    (in_tuple),
        .clique_size (clique_size_reg),
        .job_valid   (f_valid),
        .job_ready   (f_ready),
        .job         (f_job)
    );

    stsi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_job   (f_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_job   (q_job)
    );

    stsi_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (q_valid),
        .job_ready    (q_ready),
        .job          (q_job),
        .res_valid    (m_valid),
        .res_ready    (m_ready),
        .res_status   (m_status),
        .res_position (m_position),
        .res_count    (m_entry_count)
    );
endmodule

FILE: rtl/stsi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module stsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/stsi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_front
// masks and sorts the active vertices one odd-even pass per cycle
// ----------------------------------------------------------------------------
module stsi_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  stsi_pkg::tuple_t       in_tuple,
    input  logic [3:0]             clique_size,
    output logic                   job_valid,
    input  logic                   job_ready,
    output stsi_pkg::job_t         job
);
    import stsi_pkg::*;

    localparam int PASS_BITS = $clog2(MAX_CLIQUE_SIZE + 1);

    tuple_t               tup_reg, tup_next;
    logic [K_BITS-1:0]    k_reg, k_next;
    logic [PASS_BITS-1:0] pass_reg, pass_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    tuple_t               sorted;

    // one odd-even transposition pass; the parity comes from the pass count
    always_comb begin
        sorted = tup_reg;
        for (int i = 0; i < MAX_CLIQUE_SIZE - 1; i++) begin
            if ((i % 2) == int'(pass_reg[0]) && (i + 1) < int'(k_reg) &&
                tup_reg[i] > tup_reg[i+1]) begin
                sorted[i]   = tup_reg[i+1];
                sorted[i+1] = tup_reg[i];
            end
        end
    end

    assign in_ready  = !busy_reg && !done_reg;
    assign job_valid = done_reg;
    assign job.tuple = tup_reg;
    assign job.k     = k_reg;

    always_comb begin
        tup_next  = tup_reg;
        k_next    = k_reg;
        pass_next = pass_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (in_valid && in_ready) begin
            k_next = active_size(clique_size);
            for (int i = 0; i < MAX_CLIQUE_SIZE; i++) begin
                tup_next[i] = (i < int'(active_size(clique_size))) ? in_tuple[i] : '0;
            end
            pass_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            tup_next  = sorted;
            pass_next = pass_reg + PASS_BITS'(1);
            if (32'(pass_reg) == MAX_CLIQUE_SIZE - 1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (done_reg && job_ready) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pass_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            pass_reg <= pass_next;
        end
        tup_reg <= tup_next;
        k_reg   <= k_next;
    end
endmodule

FILE: rtl/stsi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_queue
// short fifo of sorted jobs between front and back
// ----------------------------------------------------------------------------
module stsi_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  stsi_pkg::job_t wr_job,
    output logic           rd_valid,
    input  logic           rd_ready,
    output stsi_pkg::job_t rd_job
);
    import stsi_pkg::*;

    localparam int PB = $clog2(QUEUE_DEPTH);

    job_t            slot_reg [QUEUE_DEPTH];
    logic [PB-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [PB:0]     cnt_reg, cnt_next;
    logic            push, pop;

    assign wr_ready = 32'(cnt_reg) < QUEUE_DEPTH;
    assign rd_valid = cnt_reg != '0;
    assign rd_job   = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wp_next  = push ? wp_reg + PB'(1) : wp_reg;
        rp_next  = pop ? rp_reg + PB'(1) : rp_reg;
        cnt_next = cnt_reg + (PB+1)'(push) - (PB+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            slot_reg[wp_reg] <= wr_job;
        end
    end
endmodule

FILE: rtl/stsi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsi_back
// binary search over the stored rows, then for a new tuple shift-up and insert in memory
// ----------------------------------------------------------------------------
module stsi_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  stsi_pkg::job_t                 job,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [1:0]                     res_status,
    output logic [stsi_pkg::IDX_BITS-1:0]  res_position,
    output logic [stsi_pkg::CNT_BITS-1:0]  res_count
);
    import stsi_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROBE = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_SREAD = 7'b0001000,
        S_SMOVE = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    job_t                job_reg, job_next;
    logic [CNT_BITS:0]   lo_reg, lo_next, hi_reg, hi_next; // signed-free, hi+1 kept
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [IDX_BITS-1:0] mid_reg, mid_next;
    logic [CNT_BITS-1:0] src_reg, src_next;
    logic [1:0]          st_reg, st_next;
    logic [IDX_BITS-1:0] pos_reg, pos_next;

    logic                ram_we;
    logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
    logic [ROW_BITS-1:0] ram_wdata, ram_rdata;
    tuple_t              row;
    logic                lt, gt;

    stsi_ram #(.WIDTH(ROW_BITS), .DEPTH(CAPACITY)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign row = tuple_t'(ram_rdata);

    // lexicographic compare over the first k positions
    always_comb begin
        lt = 1'b0;
        gt = 1'b0;
        for (int i = MAX_CLIQUE_SIZE - 1; i >= 0; i--) begin
            if (i < int'(job_reg.k) && job_reg.tuple[i] != row[i]) begin
                lt = job_reg.tuple[i] < row[i];
                gt = job_reg.tuple[i] > row[i];
            end
        end
    end

    assign job_ready    = state_reg == S_IDLE;
    assign res_valid    = state_reg == S_OUT;
    assign res_status   = st_reg;
    assign res_position = pos_reg;
    assign res_count    = cnt_reg;

    // hi is stored as hi+1 so it never goes negative
    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        cnt_next   = cnt_reg;
        mid_next   = mid_reg;
        src_next   = src_reg;
        st_next    = st_reg;
        pos_next   = pos_reg;
        ram_we     = 1'b0;
        ram_waddr  = src_reg[IDX_BITS-1:0];
        ram_wdata  = ram_rdata;
        ram_raddr  = mid_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    job_next   = job;
                    lo_next    = '0;
                    hi_next    = (CNT_BITS+1)'(cnt_reg);
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = IDX_BITS'((lo_reg + hi_reg - (CNT_BITS+1)'(1)) >> 1);
                    // issue the read of the new middle row now
                    ram_raddr  = mid_next;
                    state_next = S_CMP;
                end else if (32'(cnt_reg) >= CAPACITY) begin
                    st_next    = ST_FULL;
                    pos_next   = '0;
                    state_next = S_OUT;
                end else begin
                    st_next    = ST_INSERTED;
                    pos_next   = IDX_BITS'(lo_reg);
                    src_next   = cnt_reg;
                    state_next = (CNT_BITS+1)'(cnt_reg) > lo_reg ? S_SREAD : S_WRITE;
                end
            end
            S_CMP: begin
                // read address was mid last cycle, data now valid
                if (!lt && !gt) begin
                    st_next    = ST_PRESENT;
                    pos_next   = mid_reg;
                    state_next = S_OUT;
                end else if (lt) begin
                    hi_next    = (CNT_BITS+1)'(mid_reg);
                    state_next = S_PROBE;
                end else begin
                    lo_next    = (CNT_BITS+1)'(mid_reg) + (CNT_BITS+1)'(1);
                    state_next = S_PROBE;
                end
            end
            S_SREAD: begin
                // fetch row src-1
                ram_raddr  = IDX_BITS'(src_reg - CNT_BITS'(1));
                state_next = S_SMOVE;
            end
            S_SMOVE: begin
                ram_we     = 1'b1;
                ram_waddr  = src_reg[IDX_BITS-1:0];
                ram_wdata  = ram_rdata;
                src_next   = src_reg - CNT_BITS'(1);
                state_next = (src_next == CNT_BITS'(pos_reg)) ? S_WRITE : S_SREAD;
            end
            S_WRITE: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = ROW_BITS'(job_reg.tuple);
                cnt_next   = cnt_reg + CNT_BITS'(1);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        job_reg <= job_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        src_reg <= src_next;
        st_reg  <= st_next;
        pos_reg <= pos_next;
    end
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression for sorted_tuple_set_insert_top: tuples are sent through the
// valid/ready port, and a scoreboard keeps its own sorted set and predicts
// status, position and count for each beat. It first covers directed
// corners, then random inserts and repeats at several tuple sizes. It then
// sends a back-to-back burst of appended tuples and ends with mixed new and
// repeated tuples at the widest and narrowest sizes.
// ----------------------------------------------------------------------------
module tb;
    import stsi_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [9:0]  position;
        logic [10:0] count;
    } insert_result_t;

    class tuple_set_scoreboard;
        vertex_t        rows[CAPACITY][MAX_CLIQUE_SIZE];
        int             stored;
        int             size_reg;
        int             errors;
        insert_result_t pending_results[$];

        function new();
            stored   = 0;
            size_reg = 4;
            errors   = 0;
        endfunction

        function int used_size();
            int r;
            r = size_reg;
            if (r == 0) r = 1;
            if (r > MAX_CLIQUE_SIZE) r = MAX_CLIQUE_SIZE;
            return r;
        endfunction

        // -1 below row, 0 equal, 1 above over the first n positions
        function int order_vs_row(tuple_t t, int idx, int n);
            for (int i = 0; i < n; i++) begin
                if (t[i] < rows[idx][i]) return -1;
                if (t[i] > rows[idx][i]) return 1;
            end
            return 0;
        endfunction

        // accepted input beat: run the insert and queue what the block must return
        function void note_tuple(tuple_t raw);
            tuple_t         t;
            int             n, lo, hi, mid, c;
            vertex_t        v;
            insert_result_t r;
            n = used_size();
            t = '0;
            for (int i = 0; i < n; i++) t[i] = raw[i];
            for (int i = 1; i < n; i++) begin
                int j;
                v = t[i];
                j = i;
                while (j > 0 && t[j-1] > v) begin
                    t[j] = t[j-1];
                    j--;
                end
                t[j] = v;
            end
            lo = 0;
            hi = stored - 1;
            r.status = ST_INSERTED;
            r.position = '0;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                c = order_vs_row(t, mid, n);
                if (c == 0) begin
                    r.status = ST_PRESENT;
                    r.position = mid[9:0];
                    break;
                end
                if (c < 0) hi = mid - 1;
                else lo = mid + 1;
            end
            if (r.status == ST_INSERTED) begin
                if (stored >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int e = stored; e > lo; e--) rows[e] = rows[e-1];
                    for (int i = 0; i < MAX_CLIQUE_SIZE; i++) rows[lo][i] = t[i];
                    r.position = lo[9:0];
                    stored++;
                end
            end
            r.count = stored[10:0];
            pending_results.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic [9:0] pos, logic [10:0] cnt);
            insert_result_t r;
            if (pending_results.size() == 0) begin
                report("unexpected beat", 1, 0);
            end else begin
                r = pending_results.pop_front();
                if (st !== r.status) report("status", st, r.status);
                if (pos !== r.position) report("position", pos, r.position);
                if (cnt !== r.count) report("entry_count", cnt, r.count);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    tuple_t      s_tuple;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [9:0]  m_position;
    logic [10:0] m_entry_count;
    logic        cfg_we;
    logic [3:0]  cfg_data;

    tuple_set_scoreboard sb;
    bit          no_idle;

    sorted_tuple_set_insert_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_vertex_0   (s_tuple[0]),
        .s_vertex_1   (s_tuple[1]),
        .s_vertex_2   (s_tuple[2]),
        .s_vertex_3   (s_tuple[3]),
        .s_vertex_4   (s_tuple[4]),
        .s_vertex_5   (s_tuple[5]),
        .s_vertex_6   (s_tuple[6]),
        .s_vertex_7   (s_tuple[7]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_position   (m_position),
        .m_entry_count(m_entry_count),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one input beat; valid stays up into the next beat when there is no gap
    task automatic send_tuple(tuple_t v);
        int gap;
        s_tuple <= v;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_tuple(v);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // register writes only with the input idle and every result back
    task automatic write_clique_size(logic [3:0] val);
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_results.size() != 0);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        sb.size_reg = val;
    endtask

    function automatic tuple_t random_tuple(bit low_head);
        tuple_t t;
        for (int i = 0; i < MAX_CLIQUE_SIZE; i++) begin
            if ($urandom_range(0, 3) == 0) t[i] = vertex_t'($urandom_range(0, 7));
            else t[i] = vertex_t'($urandom);
        end
        // keep the smallest vertex below the append range
        if (low_head) t[0] = vertex_t'($urandom_range(0, 16'hEFFF));
        return t;
    endfunction

    // a stored row sent back, active part reversed, to hit the repeat path
    function automatic tuple_t stored_tuple();
        tuple_t t;
        int     idx, n;
        idx = $urandom_range(0, sb.stored - 1);
        n = sb.used_size();
        for (int i = 0; i < MAX_CLIQUE_SIZE; i++) t[i] = vertex_t'($urandom);
        for (int i = 0; i < n; i++) t[i] = sb.rows[idx][n - 1 - i];
        return t;
    endfunction

    // result side: sample at the edge, then pick the next ready level
    initial begin
        int stall;
        m_ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_status, m_position, m_entry_count);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_ready <= (stall == 0);
            end
        end
    end

    initial begin
        #40ms;
        $display("sorted_tuple_set_insert_top regression: fail");
        $finish;
    end

    initial begin
        tuple_t t;
        logic [3:0] sizes[6] = '{4'd8, 4'd0, 4'd2, 4'd15, 4'd1, 4'd5};
        sb = new();
        no_idle  = 1'b0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_tuple  = '0;
        cfg_we   = 1'b0;
        cfg_data = 4'd0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners at the reset size of four
        send_tuple('0);
        send_tuple({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hEFFF});
        send_tuple({16'h0, 16'h0, 16'h0, 16'h0, 16'h3, 16'h1, 16'h2, 16'h0});
        // same set permuted, unused lanes differ: repeat
        send_tuple({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h0, 16'h2, 16'h1, 16'h3});
        // repeated vertices within a tuple
        send_tuple({16'h0, 16'h0, 16'h0, 16'h0, 16'h5, 16'h5, 16'h5, 16'h5});
        send_tuple({16'h0, 16'h0, 16'h0, 16'h0, 16'h5, 16'h5, 16'h5, 16'h4});

        // random inserts and repeats across sizes, including the out of range ones
        foreach (sizes[p]) begin
            write_clique_size(sizes[p]);
            send_tuple({8{16'hFFFF}} & ~16'h1000);
            for (int i = 0; i < 32; i++) begin
                if (sb.stored > 0 && $urandom_range(0, 4) == 0) t = stored_tuple();
                else t = random_tuple(1'b1);
                send_tuple(t);
            end
        end

        // burst: single vertex tuples above every stored head land at the end
        write_clique_size(4'd1);
        no_idle = 1'b1;
        for (int v = 0; v < 16; v++) begin
            t = random_tuple(1'b0);
            t[0] = vertex_t'(16'hF000 + v);
            send_tuple(t);
        end
        no_idle = 1'b0;

        // mixed new and present tuples at the widest and narrowest sizes
        send_tuple({8{16'hFFFF}});
        send_tuple({8{16'hF000}});
        write_clique_size(4'd8);
        send_tuple({8{16'hFFFF}});
        for (int p = 0; p < 2; p++) begin
            if (p == 1) write_clique_size(4'd1);
            for (int i = 0; i < 30; i++) begin
                if ($urandom_range(0, 1) == 0) t = stored_tuple();
                else t = random_tuple(1'b0);
                send_tuple(t);
            end
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (sb.pending_results.size() != 0);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("sorted_tuple_set_insert_top regression: pass");
        end else begin
            $display("sorted_tuple_set_insert_top regression: fail");
        end
        $finish;
    end

endmodule
